/* rtl/jsu_pkg.sv */
// shared types and codes for the json string unescape block
`default_nettype none

package jsu_pkg;

    // decoder phase codes
    typedef enum logic [3:0] {
        PH_WAIT  = 4'd0,
        PH_BODY  = 4'd1,
        PH_ESC   = 4'd2,
        PH_HEX1  = 4'd3,
        PH_LO_BS = 4'd4,
        PH_LO_U  = 4'd5,
        PH_HEX2  = 4'd6
    } phase_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    // error codes
    typedef enum logic [2:0] {
        ERR_EXPECT_QUOTE  = 3'd0,
        ERR_UNTERMINATED  = 3'd1,
        ERR_CONTROL_CHAR  = 3'd2,
        ERR_TRUNC_ESCAPE  = 3'd3,
        ERR_BAD_ESCAPE    = 3'd4,
        ERR_BAD_HEX       = 3'd5,
        ERR_UNPAIRED_SURR = 3'd6
    } err_t;

    localparam int unsigned MAX_RES = 4;

    // one result item
    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        err_t       code;
    } res_t;

    // all results caused by one input item, first in entry 0
    typedef struct packed {
        res_t [MAX_RES-1:0] res;
        logic [2:0]         count;
    } grp_t;

endpackage

`default_nettype wire

/* rtl/jsu_decode.sv */
// phase machine and escape decoder producing the result group of one item
`default_nettype none

module jsu_decode (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        accept,
    input  wire logic [7:0]  in_byte,
    input  wire logic        at_end,
    output jsu_pkg::grp_t    grp
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [5:0] HI_SURR  = 6'b110110;
    localparam logic [5:0] LO_SURR  = 6'b110111;

    phase_t      phase_reg, phase_next;
    logic [15:0] code_unit_reg, code_unit_next;
    logic [9:0]  high_half_reg, high_half_next;
    logic [1:0]  hex_count_reg, hex_count_next;

    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] cu_shift;
    logic        cu_hi, cu_lo;
    logic [20:0] cp_pair;
    grp_t        utf_bmp, utf_pair;

    // hex digit decode
    always_comb begin
        hex_ok  = 1'b0;
        hex_val = in_byte[3:0];
        if (!at_end) begin
            if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
                hex_ok = 1'b1;
            end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                         (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
                hex_ok  = 1'b1;
                hex_val = in_byte[3:0] + 4'd9;
            end
        end
    end

    assign cu_shift = {code_unit_reg[11:0], hex_val};
    assign cu_hi    = (cu_shift[15:10] == HI_SURR);
    assign cu_lo    = (cu_shift[15:10] == LO_SURR);
    assign cp_pair  = 21'h10000 + {1'b0, high_half_reg, cu_shift[9:0]};

    // code point to utf-8 bytes
    function automatic grp_t utf8_enc(input logic [20:0] cp);
        grp_t g;
        g = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            g.res[i].kind = KIND_BYTE;
            g.res[i].code = ERR_EXPECT_QUOTE;
        end
        if (cp < 21'h80) begin
            g.count       = 3'd1;
            g.res[0].data = cp[7:0];
        end else if (cp < 21'h800) begin
            g.count       = 3'd2;
            g.res[0].data = {3'b110, cp[10:6]};
            g.res[1].data = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            g.count       = 3'd3;
            g.res[0].data = {4'b1110, cp[15:12]};
            g.res[1].data = {2'b10, cp[11:6]};
            g.res[2].data = {2'b10, cp[5:0]};
        end else begin
            g.count       = 3'd4;
            g.res[0].data = {5'b11110, cp[20:18]};
            g.res[1].data = {2'b10, cp[17:12]};
            g.res[2].data = {2'b10, cp[11:6]};
            g.res[3].data = {2'b10, cp[5:0]};
        end
        return g;
    endfunction

    assign utf_bmp  = utf8_enc({5'd0, cu_shift});
    assign utf_pair = utf8_enc(cp_pair);

    // next state
    always_comb begin
        phase_next     = phase_reg;
        code_unit_next = code_unit_reg;
        high_half_next = high_half_reg;
        hex_count_next = hex_count_reg;
        if (accept) begin
            case (phase_reg)
                PH_BODY: begin
                    if (at_end || in_byte == CH_QUOTE || in_byte < CH_SPACE) begin
                        phase_next = PH_WAIT;
                    end else if (in_byte == CH_BSL) begin
                        phase_next = PH_ESC;
                    end
                end
                PH_ESC: begin
                    if (at_end) begin
                        phase_next = PH_WAIT;
                    end else begin
                        case (in_byte)
                            CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R,
                            CH_T: phase_next = PH_BODY;
                            CH_U: begin
                                phase_next     = PH_HEX1;
                                code_unit_next = '0;
                                hex_count_next = '0;
                            end
                            default: phase_next = PH_WAIT;
                        endcase
                    end
                end
                PH_HEX1: begin
                    if (!hex_ok) begin
                        phase_next = PH_WAIT;
                    end else begin
                        code_unit_next = cu_shift;
                        if (hex_count_reg != 2'd3) begin
                            hex_count_next = hex_count_reg + 2'd1;
                        end else begin
                            hex_count_next = '0;
                            if (cu_hi) begin
                                high_half_next = cu_shift[9:0];
                                phase_next     = PH_LO_BS;
                            end else if (cu_lo) begin
                                phase_next = PH_WAIT;
                            end else begin
                                phase_next = PH_BODY;
                            end
                        end
                    end
                end
                PH_LO_BS: begin
                    phase_next = (at_end || in_byte != CH_BSL) ? PH_WAIT : PH_LO_U;
                end
                PH_LO_U: begin
                    if (at_end || in_byte != CH_U) begin
                        phase_next = PH_WAIT;
                    end else begin
                        phase_next     = PH_HEX2;
                        code_unit_next = '0;
                        hex_count_next = '0;
                    end
                end
                PH_HEX2: begin
                    if (!hex_ok) begin
                        phase_next = PH_WAIT;
                    end else begin
                        code_unit_next = cu_shift;
                        if (hex_count_reg != 2'd3) begin
                            hex_count_next = hex_count_reg + 2'd1;
                        end else begin
                            hex_count_next = '0;
                            phase_next     = cu_lo ? PH_BODY : PH_WAIT;
                        end
                    end
                end
                default: begin
                    phase_next = (!at_end && in_byte == CH_QUOTE) ? PH_BODY : PH_WAIT;
                end
            endcase
        end
    end

    // result group of the current item
    always_comb begin
        grp = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            grp.res[i].kind = KIND_BYTE;
            grp.res[i].code = ERR_EXPECT_QUOTE;
        end
        case (phase_reg)
            PH_BODY: begin
                grp.count = 3'd1;
                if (at_end) begin
                    grp.res[0].kind = KIND_ERR;
                    grp.res[0].code = ERR_UNTERMINATED;
                end else if (in_byte == CH_QUOTE) begin
                    grp.res[0].kind = KIND_DONE;
                end else if (in_byte < CH_SPACE) begin
                    grp.res[0].kind = KIND_ERR;
                    grp.res[0].code = ERR_CONTROL_CHAR;
                end else if (in_byte == CH_BSL) begin
                    grp.count = 3'd0;
                end else begin
                    grp.res[0].data = in_byte;
                end
            end
            PH_ESC: begin
                grp.count = 3'd1;
                if (at_end) begin
                    grp.res[0].kind = KIND_ERR;
                    grp.res[0].code = ERR_TRUNC_ESCAPE;
                end else begin
                    case (in_byte)
                        CH_QUOTE, CH_BSL, CH_SLASH: grp.res[0].data = in_byte;
                        CH_B: grp.res[0].data = 8'h08;
                        CH_F: grp.res[0].data = 8'h0C;
                        CH_N: grp.res[0].data = 8'h0A;
                        CH_R: grp.res[0].data = 8'h0D;
                        CH_T: grp.res[0].data = 8'h09;
                        CH_U: grp.count = 3'd0;
                        default: begin
                            grp.res[0].kind = KIND_ERR;
                            grp.res[0].code = ERR_BAD_ESCAPE;
                        end
                    endcase
                end
            end
            PH_HEX1: begin
                if (!hex_ok) begin
                    grp.count       = 3'd1;
                    grp.res[0].kind = KIND_ERR;
                    grp.res[0].code = ERR_BAD_HEX;
                end else if (hex_count_reg == 2'd3 && cu_lo) begin
                    grp.count       = 3'd1;
                    grp.res[0].kind = KIND_ERR;
                    grp.res[0].code = ERR_UNPAIRED_SURR;
                end else if (hex_count_reg == 2'd3 && !cu_hi) begin
                    grp = utf_bmp;
                end
            end
            PH_LO_BS: begin
                if (at_end || in_byte != CH_BSL) begin
                    grp.count       = 3'd1;
                    grp.res[0].kind = KIND_ERR;
                    grp.res[0].code = ERR_UNPAIRED_SURR;
                end
            end
            PH_LO_U: begin
                if (at_end || in_byte != CH_U) begin
                    grp.count       = 3'd1;
                    grp.res[0].kind = KIND_ERR;
                    grp.res[0].code = ERR_UNPAIRED_SURR;
                end
            end
            PH_HEX2: begin
                if (!hex_ok || (hex_count_reg == 2'd3 && !cu_lo)) begin
                    grp.count       = 3'd1;
                    grp.res[0].kind = KIND_ERR;
                    grp.res[0].code = ERR_UNPAIRED_SURR;
                end else if (hex_count_reg == 2'd3) begin
                    grp = utf_pair;
                end
            end
            default: begin
                if (at_end || in_byte != CH_QUOTE) begin
                    grp.count       = 3'd1;
                    grp.res[0].kind = KIND_ERR;
                    grp.res[0].code = ERR_EXPECT_QUOTE;
                end
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_WAIT;
            code_unit_reg <= '0;
            high_half_reg <= '0;
            hex_count_reg <= '0;
        end else begin
            phase_reg     <= phase_next;
            code_unit_reg <= code_unit_next;
            high_half_reg <= high_half_next;
            hex_count_reg <= hex_count_next;
        end
    end

`ifndef SYNTHESIS
    // an error is always a lone result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (grp.count != 3'd0 && grp.res[0].kind == KIND_ERR) |-> grp.count == 3'd1)
        else $error("error result not alone in its group");

    // an accepted item that fails sends the decoder back to waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && grp.count != 3'd0 && grp.res[0].kind == KIND_ERR) |=>
        phase_reg == PH_WAIT)
        else $error("decoder did not return to waiting after an error");

    // one item never causes more than four results
    assert property (@(posedge aclk) disable iff (!aresetn)
        grp.count <= 3'd4)
        else $error("result group larger than four");
`endif

endmodule

`default_nettype wire

/* rtl/jsu_out_buf.sv */
// result register that drains a group of up to four results one per cycle while m_ready is high
`default_nettype none

module jsu_out_buf (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  jsu_pkg::grp_t    grp,
    output logic             space,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic [1:0]       m_kind,
    output logic [2:0]       m_error_code,
    output logic             m_last_of_run
);
    import jsu_pkg::*;

    res_t [MAX_RES-1:0] ent_reg, ent_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               pop;

    assign m_valid       = (cnt_reg != 3'd0);
    assign pop           = m_valid && m_ready;
    assign space         = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_ready);
    assign m_out_byte    = ent_reg[0].data;
    assign m_kind        = ent_reg[0].kind;
    assign m_error_code  = ent_reg[0].code;
    assign m_last_of_run = (cnt_reg == 3'd1);

    // load a new group or shift the remaining results down
    always_comb begin
        ent_next = ent_reg;
        cnt_next = cnt_reg;
        if (load) begin
            ent_next = grp.res;
            cnt_next = grp.count;
        end else if (pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                ent_next[i] = ent_reg[i+1];
            end
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    // fill level never exceeds the group size
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4)
        else $error("result count out of range");

    // a group is only loaded over an empty or finishing buffer
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (cnt_reg == 3'd0 || (cnt_reg == 3'd1 && m_ready)))
        else $error("group loaded over pending results");

    // taking the last result with nothing new leaves the buffer empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && cnt_reg == 3'd1 && !load) |=> cnt_reg == 3'd0)
        else $error("buffer not empty after last result");
`endif

endmodule

`default_nettype wire

/* rtl/json_string_unescape_utf8.sv */
// top level of the json string literal to utf-8 decoder
// Usage:
//   Input channel (s_valid/s_ready) carries one byte of a JSON string literal
//   per item, starting at the opening quote; s_at_end marks end of text.
//   Result channel (m_valid/m_ready) carries one result per item: a decoded
//   utf-8 content byte, a string-complete mark or an error code.
//   m_last_of_run flags the final result caused by one input item.
// The first result of an item appears in the cycle after it is accepted.
// Throughput: one input item per cycle while each causes at most one result
//   and m_ready is high; an item causing several results (up to four for a
//   surrogate pair) holds the input until its last result is being taken, set
//   by the single output register draining one result per cycle while m_ready is high.
// Reset: aresetn (synchronous, active low) clears the phase machine to
//   waiting for an opening quote and empties the output register.
// Stall: when m_ready is low the pending result holds and s_ready drops
//   until the last pending result of the current group is taken.
`default_nettype none

module json_string_unescape_utf8 (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_at_end,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic [1:0]      m_kind,
    output logic [2:0]      m_error_code,
    output logic            m_last_of_run
);
    import jsu_pkg::*;

    grp_t grp;
    logic accept;
    logic space;

    assign s_ready = space;
    assign accept  = s_valid && space;

    // escape decoder and phase machine
    jsu_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .at_end  (s_at_end),
        .grp     (grp)
    );

    // result register
    jsu_out_buf u_out_buf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept),
        .grp           (grp),
        .space         (space),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_kind        (m_kind),
        .m_error_code  (m_error_code),
        .m_last_of_run (m_last_of_run)
    );

endmodule

`default_nettype wire
